### src/dgcd_pkg.sv
// Package: sizes, codes and controller/datapath interface types for the cycle detector.
`default_nettype none
package dgcd_pkg;

    localparam int NODES       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int VW          = $clog2(NODES);        // vertex index
    localparam int PW          = $clog2(NODES + 1);    // vertex or NODES (root mark, end of row)
    localparam int KW          = $clog2(MAX_RESULTS);  // result counter
    localparam int FW          = 4;                    // vertex field width on the ports

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_CHECK = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        WHITE = 2'd0,
        GREY  = 2'd1,
        BLACK = 2'd2
    } t_color;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROOT,
        ST_STEP,
        ST_EMIT,
        ST_NONE
    } t_state;

    typedef struct packed {
        logic edge_wr;
        logic clear;
        logic init;
        logic sel_root;
        logic root_push;
        logic root_skip;
        logic step_pop;
        logic step_adv;
        logic step_push;
        logic step_hit;
        logic emit_load;
        logic none_load;
    } t_cmd;

    typedef struct packed {
        logic root_end;
        logic color_white;
        logic color_grey;
        logic top_done;
        logic edge_set;
        logic sp_one;
        logic stack_full;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

### src/dgcd_ctrl.sv
// Controller: sequences edge updates, the depth-first search and the result beats.
`default_nettype none
module dgcd_ctrl
    import dgcd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [1:0]  i_op,
    input  wire t_status     i_status,
    output logic             o_ready,
    output t_cmd             o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && (i_op == OP_CHECK)) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                n_state = ST_ROOT;
            end
            ST_ROOT: begin
                if (i_status.root_end) begin
                    n_state = ST_NONE;
                end else if (i_status.color_white) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (i_status.top_done) begin
                    if (i_status.sp_one) begin
                        n_state = ST_ROOT;
                    end
                end else if (i_status.edge_set && i_status.color_grey) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free && i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_NONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (i_op)
                        OP_WRITE: o_cmd.edge_wr = 1'b1;
                        OP_CLEAR: o_cmd.clear   = 1'b1;
                        default:  o_cmd.edge_wr = 1'b0;
                    endcase
                end
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
            end
            ST_ROOT: begin
                o_cmd.sel_root = 1'b1;
                if (!i_status.root_end) begin
                    if (i_status.color_white) begin
                        o_cmd.root_push = 1'b1;
                    end else begin
                        o_cmd.root_skip = 1'b1;
                    end
                end
            end
            ST_STEP: begin
                if (i_status.top_done) begin
                    o_cmd.step_pop = 1'b1;
                end else begin
                    o_cmd.step_adv = 1'b1;
                    if (i_status.edge_set && i_status.color_white && !i_status.stack_full) begin
                        o_cmd.step_push = 1'b1;
                    end
                    if (i_status.edge_set && i_status.color_grey) begin
                        o_cmd.step_hit = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                o_cmd.emit_load = i_status.out_free;
            end
            ST_NONE: begin
                o_cmd.none_load = i_status.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### src/dgcd_dp.sv
// Datapath: adjacency matrix, marks, parent links, search stack and result register.
`default_nettype none
module dgcd_dp
    import dgcd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    input  wire logic [FW-1:0] i_from_vertex,
    input  wire logic [FW-1:0] i_to_vertex,
    input  wire logic          i_edge_present,
    input  wire logic          i_ready,
    output t_status            o_status,
    output logic               o_valid,
    output logic               o_cycle_found,
    output logic [FW-1:0]      o_cycle_vertex,
    output logic               o_last
);

    logic [NODES-1:0] r_adj    [NODES];
    t_color           r_color  [NODES];
    logic [PW-1:0]    r_parent [NODES];
    logic [VW-1:0]    r_stk_v  [NODES];
    logic [PW-1:0]    r_stk_n  [NODES];

    logic [PW-1:0] r_sp;
    logic [PW-1:0] r_r;
    logic [VW-1:0] r_x;
    logic [VW-1:0] r_close;
    logic [KW-1:0] r_k;

    logic          r_out_valid;
    logic          r_out_found;
    logic [FW-1:0] r_out_vertex;
    logic          r_out_last;

    logic [VW-1:0] top;
    logic [VW-1:0] u;
    logic [PW-1:0] n;
    logic [VW-1:0] nv;
    logic [VW-1:0] root_v;
    logic [VW-1:0] c_addr;
    t_color        c_rd;
    logic [PW-1:0] parent_x;
    logic          wr_ok;
    logic          out_free;
    logic          emit_last;

    always_comb begin
        top       = VW'(r_sp - PW'(1));
        u         = r_stk_v[top];
        n         = r_stk_n[top];
        nv        = n[VW-1:0];
        root_v    = r_r[VW-1:0];
        c_addr    = i_cmd.sel_root ? root_v : nv;
        c_rd      = r_color[c_addr];
        parent_x  = r_parent[r_x];
        wr_ok     = (32'(i_from_vertex) < NODES) && (32'(i_to_vertex) < NODES);
        out_free  = !r_out_valid || i_ready;
        // chain ends at the grey vertex, at a search root, or at the result limit
        emit_last = (r_x == r_close) || (parent_x >= PW'(NODES))
                    || (r_k == KW'(MAX_RESULTS - 1));
    end

    always_comb begin
        o_status.root_end    = (r_r == PW'(NODES));
        o_status.color_white = (c_rd == WHITE);
        o_status.color_grey  = (c_rd == GREY);
        o_status.top_done    = (n >= PW'(NODES));
        o_status.edge_set    = r_adj[u][nv];
        o_status.sp_one      = (r_sp == PW'(1));
        o_status.stack_full  = (r_sp >= PW'(NODES));
        o_status.emit_last   = emit_last;
        o_status.out_free    = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                r_adj[i] <= '0;
            end
        end else if (i_cmd.clear) begin
            for (int i = 0; i < NODES; i++) begin
                r_adj[i] <= '0;
            end
        end else if (i_cmd.edge_wr && wr_ok) begin
            r_adj[VW'(i_from_vertex)][VW'(i_to_vertex)] <= i_edge_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            for (int i = 0; i < NODES; i++) begin
                r_color[i]  <= WHITE;
                r_parent[i] <= PW'(NODES);
            end
        end
        if (i_cmd.root_push) begin
            r_color[root_v]  <= GREY;
            r_parent[root_v] <= PW'(NODES);
        end
        if (i_cmd.step_pop) begin
            r_color[u] <= BLACK;
        end
        if (i_cmd.step_push) begin
            r_color[nv]  <= GREY;
            r_parent[nv] <= PW'(u);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_push) begin
            r_stk_v[0] <= root_v;
            r_stk_n[0] <= '0;
        end
        if (i_cmd.step_adv) begin
            r_stk_n[top] <= PW'(n + PW'(1));
        end
        if (i_cmd.step_push) begin
            r_stk_v[r_sp[VW-1:0]] <= nv;
            r_stk_n[r_sp[VW-1:0]] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_cmd.root_push) begin
            r_sp <= PW'(1);
        end else if (i_cmd.step_pop) begin
            r_sp <= PW'(r_sp - PW'(1));
        end else if (i_cmd.step_hit) begin
            r_sp <= '0;
        end else if (i_cmd.step_push) begin
            r_sp <= PW'(r_sp + PW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_r <= '0;
        end else if (i_cmd.root_push || i_cmd.root_skip) begin
            r_r <= PW'(r_r + PW'(1));
        end
        if (i_cmd.step_hit) begin
            r_x     <= u;
            r_close <= nv;
            r_k     <= '0;
        end else if (i_cmd.emit_load) begin
            r_x <= VW'(parent_x);
            r_k <= KW'(r_k + KW'(1));
        end
    end

    // result register: a beat waits here while the search or chain walk goes on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load || i_cmd.none_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_found  <= 1'b1;
            r_out_vertex <= FW'(r_x);
            r_out_last   <= emit_last;
        end else if (i_cmd.none_load) begin
            r_out_found  <= 1'b0;
            r_out_vertex <= '0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_cycle_found  = r_out_found;
    assign o_cycle_vertex = r_out_vertex;
    assign o_last         = r_out_last;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= PW'(NODES))
        else $error("search stack pointer beyond vertex count");

    a_hit_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step_hit |=> (r_sp == '0))
        else $error("stack not emptied after back edge");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_load || i_cmd.none_load) |-> out_free)
        else $error("result beat loaded over a pending one");

    a_push_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step_push |=> (r_color[$past(nv)] == GREY) && (r_sp == $past(r_sp) + PW'(1)))
        else $error("push did not mark the vertex grey");
`endif

endmodule
`default_nettype wire

### src/directed_graph_cycle_detect.sv
// Directed-graph cycle detector: adjacency matrix plus DFS controller and datapath.
// Edge write and clear beats: accepted while idle, no result.
// Check beat: marks are reset, then each root is probed (plus an end probe), the stack is
// stepped through every vertex slot of each visited vertex, and the result is loaded;
// then one result beat per cycle while the output is taken.
// Input is held off until the last beat is loaded.
// Synchronous active-low reset empties the matrix and the result register.
`default_nettype none
module directed_graph_cycle_detect
    import dgcd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_op,
    input  wire logic [FW-1:0] i_from_vertex,
    input  wire logic [FW-1:0] i_to_vertex,
    input  wire logic          i_edge_present,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_cycle_found,
    output logic [FW-1:0]      o_cycle_vertex,
    output logic               o_last
);

    t_cmd    cmd;
    t_status status;

    dgcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    dgcd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_from_vertex  (i_from_vertex),
        .i_to_vertex    (i_to_vertex),
        .i_edge_present (i_edge_present),
        .i_ready        (i_ready),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_cycle_found  (o_cycle_found),
        .o_cycle_vertex (o_cycle_vertex),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire
